@@ rtl/uto_pkg.sv @@
// uto_pkg: shared types and constants of the oversampled uart transceiver
// no dependencies; imported by uto_front, uto_core and the top level
`default_nettype none

package uto_pkg;

  // request kinds
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_PUT  = 1'b1
  } op_t;

  // transmitter phases
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_SEND  = 2'd2,
    PH_STOP  = 2'd3
  } tx_phase_t;

  // one classified request as it travels from front to back
  typedef struct packed {
    op_t        op;
    logic       rx_level;
    logic [7:0] wr_byte;
  } uto_item_t;

  localparam logic [7:0] TX_DIV_RELOAD = 8'd3;
  localparam logic [7:0] TX_DIV_ARM    = 8'd2;
  localparam logic [3:0] TX_FRAME_BITS = 4'd8;
  localparam logic [2:0] RX_START_DIV  = 3'd4;
  localparam logic [2:0] RX_BIT_DIV    = 3'd3;
  localparam logic [3:0] RX_FRAME_BITS = 4'd9;

endpackage

`default_nettype wire

@@ rtl/uto_front.sv @@
// uto_front: accepts requests, classifies them and holds them in a 2-entry queue
// depends on uto_pkg
`default_nettype none

module uto_front
  import uto_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_op,
  input  wire logic       in_rx_level,
  input  wire logic [7:0] in_wr_byte,
  output logic            item_valid,
  output uto_item_t       item,
  input  wire logic       item_pop
);

  uto_item_t  slot_r [2];
  logic       wr_sel_r, wr_sel_nxt;
  logic       rd_sel_r, rd_sel_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  uto_item_t  cls;

  assign in_stall   = (count_r == 2'd2);
  assign push       = in_valid && !in_stall;
  assign item_valid = (count_r != 2'd0);
  assign item       = slot_r[rd_sel_r];

  // classify the raw request
  always_comb begin
    cls.op       = in_op ? OP_PUT : OP_TICK;
    cls.rx_level = in_rx_level;
    cls.wr_byte  = in_wr_byte;
  end

  always_comb begin
    wr_sel_nxt = push ? ~wr_sel_r : wr_sel_r;
    rd_sel_nxt = item_pop ? ~rd_sel_r : rd_sel_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, item_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_sel_r <= 1'b0;
      rd_sel_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_sel_r <= wr_sel_nxt;
      rd_sel_r <= rd_sel_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_sel_r] <= cls;
    end
  end

endmodule

`default_nettype wire

@@ rtl/uto_core.sv @@
// uto_core: executes ticks and puts, holds receiver, transmitter and tx queue
// depends on uto_pkg; drives the registered result channel
`default_nettype none

module uto_core
  import uto_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       item_valid,
  input  wire uto_item_t  item,
  output logic            item_pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_tx_level,
  output logic            out_put_status,
  output logic            out_rx_valid,
  output logic [7:0]      out_rx_byte,
  output logic            out_queue_full
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    next_ptr = (p == LastPtr) ? '0 : p + PtrW'(1);
  endfunction

  // tx queue storage
  logic [7:0] mem [QUEUE_DEPTH];
  logic [7:0] head_r;

  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic            not_full_r, not_full_nxt;
  logic            pending_r, pending_nxt;
  tx_phase_t       phase_r, phase_nxt;
  logic [7:0]      tx_div_r, tx_div_nxt;
  logic [3:0]      tx_bits_r, tx_bits_nxt;
  logic [7:0]      tx_shift_r, tx_shift_nxt;
  logic            tx_line_r, tx_line_nxt;
  logic            rx_busy_r, rx_busy_nxt;
  logic [2:0]      rx_div_r, rx_div_nxt;
  logic [3:0]      rx_bits_r, rx_bits_nxt;
  logic [7:0]      rx_shift_r, rx_shift_nxt;

  logic            wr_en;
  logic            status;
  logic            rvalid;
  logic [7:0]      rbyte;

  logic            out_valid_r;
  logic            out_put_status_r, out_rx_valid_r, out_queue_full_r;
  logic [7:0]      out_rx_byte_r;

  assign item_pop = item_valid && (!out_valid_r || !out_stall);

  always_comb begin
    rd_ptr_nxt   = rd_ptr_r;
    wr_ptr_nxt   = wr_ptr_r;
    not_full_nxt = not_full_r;
    pending_nxt  = pending_r;
    phase_nxt    = phase_r;
    tx_div_nxt   = tx_div_r;
    tx_bits_nxt  = tx_bits_r;
    tx_shift_nxt = tx_shift_r;
    tx_line_nxt  = tx_line_r;
    rx_busy_nxt  = rx_busy_r;
    rx_div_nxt   = rx_div_r;
    rx_bits_nxt  = rx_bits_r;
    rx_shift_nxt = rx_shift_r;
    wr_en        = 1'b0;
    status       = 1'b0;
    rvalid       = 1'b0;
    rbyte        = 8'd0;

    if (item.op == OP_PUT) begin
      if (not_full_r) begin
        wr_en       = 1'b1;
        wr_ptr_nxt  = next_ptr(wr_ptr_r);
        pending_nxt = 1'b1;
        if (wr_ptr_nxt == rd_ptr_r) begin
          not_full_nxt = 1'b0;
        end
      end else begin
        status = 1'b1;
      end
    end else begin
      // receiver
      if (rx_busy_r) begin
        rx_div_nxt = rx_div_r - 3'd1;
        if (rx_div_nxt == 3'd0) begin
          rx_div_nxt  = RX_BIT_DIV;
          rx_bits_nxt = rx_bits_r - 4'd1;
          if (rx_bits_nxt == 4'd0) begin
            rvalid      = 1'b1;
            rbyte       = rx_shift_r;
            rx_busy_nxt = 1'b0;
          end else begin
            rx_shift_nxt = {item.rx_level, rx_shift_r[7:1]};
          end
        end
      end else if (!item.rx_level) begin
        rx_busy_nxt = 1'b1;
        rx_div_nxt  = RX_START_DIV;
        rx_bits_nxt = RX_FRAME_BITS;
      end

      // transmitter
      tx_div_nxt = tx_div_r - 8'd1;
      if (tx_div_nxt == 8'd0) begin
        tx_div_nxt = TX_DIV_RELOAD;
        unique case (phase_r)
          PH_START: begin
            tx_line_nxt  = 1'b0;
            tx_shift_nxt = head_r;
            not_full_nxt = 1'b1;
            rd_ptr_nxt   = next_ptr(rd_ptr_r);
            if (rd_ptr_nxt == wr_ptr_r) begin
              pending_nxt = 1'b0;
            end
            tx_bits_nxt = TX_FRAME_BITS;
            phase_nxt   = PH_SEND;
          end
          PH_SEND: begin
            tx_line_nxt  = tx_shift_r[0];
            tx_shift_nxt = {1'b0, tx_shift_r[7:1]};
            tx_bits_nxt  = tx_bits_r - 4'd1;
            if (tx_bits_nxt == 4'd0) begin
              phase_nxt = PH_STOP;
            end
          end
          PH_STOP: begin
            tx_line_nxt = 1'b1;
            phase_nxt   = PH_IDLE;
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
      if (tx_div_nxt == TX_DIV_ARM && phase_nxt == PH_IDLE && pending_nxt) begin
        phase_nxt = PH_START;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r   <= '0;
      wr_ptr_r   <= '0;
      not_full_r <= 1'b1;
      pending_r  <= 1'b0;
      phase_r    <= PH_IDLE;
      tx_div_r   <= 8'd0;
      tx_bits_r  <= 4'd0;
      tx_shift_r <= 8'd0;
      tx_line_r  <= 1'b1;
      rx_busy_r  <= 1'b0;
      rx_div_r   <= 3'd0;
      rx_bits_r  <= 4'd0;
      rx_shift_r <= 8'd0;
    end else if (item_pop) begin
      rd_ptr_r   <= rd_ptr_nxt;
      wr_ptr_r   <= wr_ptr_nxt;
      not_full_r <= not_full_nxt;
      pending_r  <= pending_nxt;
      phase_r    <= phase_nxt;
      tx_div_r   <= tx_div_nxt;
      tx_bits_r  <= tx_bits_nxt;
      tx_shift_r <= tx_shift_nxt;
      tx_line_r  <= tx_line_nxt;
      rx_busy_r  <= rx_busy_nxt;
      rx_div_r   <= rx_div_nxt;
      rx_bits_r  <= rx_bits_nxt;
      rx_shift_r <= rx_shift_nxt;
    end
  end

  // queue write and registered head read, with bypass of a same-cycle write
  always_ff @(posedge clk) begin
    if (item_pop) begin
      if (wr_en) begin
        mem[wr_ptr_r] <= item.wr_byte;
      end
      if (wr_en && (wr_ptr_r == rd_ptr_nxt)) begin
        head_r <= item.wr_byte;
      end else begin
        head_r <= mem[rd_ptr_nxt];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (item_pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      out_put_status_r <= status;
      out_rx_valid_r   <= rvalid;
      out_rx_byte_r    <= rbyte;
      out_queue_full_r <= !not_full_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_tx_level   = tx_line_r;
  assign out_put_status = out_put_status_r;
  assign out_rx_valid   = out_rx_valid_r;
  assign out_rx_byte    = out_rx_byte_r;
  assign out_queue_full = out_queue_full_r;

`ifndef SYNTHESIS
  a_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    !not_full_r |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue full with unequal pointers");

  a_empty_state: assert property (@(posedge clk) disable iff (!rst_n)
    !pending_r |-> (wr_ptr_r == rd_ptr_r) && not_full_r)
    else $error("queue empty but pointers or full flag disagree");

  a_rx_div: assert property (@(posedge clk) disable iff (!rst_n)
    rx_busy_r |-> (rx_div_r != 3'd0) && (rx_div_r <= RX_START_DIV))
    else $error("receiver divider out of range while busy");

  a_tx_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SEND) |-> (tx_bits_r != 4'd0) && (tx_bits_r <= TX_FRAME_BITS))
    else $error("transmit bit count out of range while sending");

  a_pop_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !item_pop)
    else $error("request executed while result register is held");
`endif

endmodule

`default_nettype wire

@@ rtl/uart_transceiver_oversampled.sv @@
// uart_transceiver_oversampled: top level of the 8n1 uart with 3x oversampling
// depends on uto_pkg, uto_front and uto_core
//
// usage
//   in channel (in_valid / in_stall): one request per handshake. in_op = 0 is an
//   oversampling tick carrying in_rx_level, in_op = 1 puts in_wr_byte into the
//   transmit queue (QUEUE_DEPTH entries)
//   out channel (out_valid / out_stall): exactly one result per request, in order:
//   transmit line level, put status, received byte with its valid flag, queue full
//   path: a request is held in the front queue, then the execute step pops it
//   and loads the result register; out_stall can hold a request in the queue
//   throughput: one request per cycle while no result is held by out_stall
//   a 2-entry request queue sits between front and back, so the front keeps taking
//   requests while a result waits; when out_stall holds, up to two more requests
//   are taken before in_stall rises
//   reset (rst_n low, synchronous): queues empty, transmitter idle with the line
//   high, receiver hunting for a start level; transmit queue contents are not
//   cleared and only entries written since reset are ever sent
//   tx line is updated only by ticks; puts leave receiver and transmitter alone
`default_nettype none

module uart_transceiver_oversampled
  import uto_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_op,
  input  wire logic       in_rx_level,
  input  wire logic [7:0] in_wr_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_tx_level,
  output logic            out_put_status,
  output logic            out_rx_valid,
  output logic [7:0]      out_rx_byte,
  output logic            out_queue_full
);

  // request path between front and back
  logic      item_valid;
  uto_item_t item;
  logic      item_pop;

  // front: accept and classify requests, buffer two of them
  uto_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_op       (in_op),
    .in_rx_level (in_rx_level),
    .in_wr_byte  (in_wr_byte),
    .item_valid  (item_valid),
    .item        (item),
    .item_pop    (item_pop)
  );

  // back: receiver, transmitter, tx queue and result register
  uto_core #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item_valid),
    .item           (item),
    .item_pop       (item_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_tx_level   (out_tx_level),
    .out_put_status (out_put_status),
    .out_rx_valid   (out_rx_valid),
    .out_rx_byte    (out_rx_byte),
    .out_queue_full (out_queue_full)
  );

endmodule

`default_nettype wire

@@ tb/uart_line_predictor_pkg.sv @@
// uart_line_predictor_pkg: result type and predictor class for the oversampled uart bench
// depends on uto_pkg for the request kind, the transmitter phases and the timing constants
package uart_line_predictor_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import uto_pkg::*;

  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic       tx_level;
    logic       put_status;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       queue_full;
  } uart_result_t;

  class uart_line_predictor;
    logic [7:0]       tx_fifo [QUEUE_DEPTH];
    logic [PTR_W-1:0] rd_ptr;
    logic [PTR_W-1:0] wr_ptr;
    logic             fifo_not_full;
    logic             tx_pending;
    tx_phase_t        tx_phase;
    logic [7:0]       tx_div;
    logic [3:0]       tx_bits;
    logic [7:0]       tx_shift;
    logic             tx_line;
    logic             rx_busy;
    logic [2:0]       rx_div;
    logic [3:0]       rx_bits;
    logic [7:0]       rx_shift;
    uart_result_t     predicted_results[$];
    int               errors;

    function new();
      foreach (tx_fifo[i]) tx_fifo[i] = 8'h00;
      rd_ptr = '0;
      wr_ptr = '0;
      fifo_not_full = 1'b1;
      tx_pending = 1'b0;
      tx_phase = PH_IDLE;
      tx_div = 8'd0;
      tx_bits = 4'd0;
      tx_shift = 8'd0;
      tx_line = 1'b1;
      rx_busy = 1'b0;
      rx_div = 3'd0;
      rx_bits = 4'd0;
      rx_shift = 8'd0;
      errors = 0;
    endfunction

    function logic [PTR_W-1:0] step_ptr(logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // advance the model by one accepted request and queue its result
    function void note_request(op_t op, logic level, logic [7:0] wr_byte);
      uart_result_t r;
      r = '0;
      if (op == OP_PUT) begin
        if (fifo_not_full) begin
          tx_fifo[wr_ptr] = wr_byte;
          wr_ptr = step_ptr(wr_ptr);
          if (wr_ptr == rd_ptr) fifo_not_full = 1'b0;
          tx_pending = 1'b1;
        end else begin
          r.put_status = 1'b1;
        end
      end else begin
        // receiver
        if (rx_busy) begin
          rx_div = rx_div - 3'd1;
          if (rx_div == 3'd0) begin
            rx_div = RX_BIT_DIV;
            rx_bits = rx_bits - 4'd1;
            if (rx_bits == 4'd0) begin
              r.rx_valid = 1'b1;
              r.rx_byte = rx_shift;
              rx_busy = 1'b0;
            end else begin
              rx_shift = {level, rx_shift[7:1]};
            end
          end
        end else if (!level) begin
          rx_busy = 1'b1;
          rx_div = RX_START_DIV;
          rx_bits = RX_FRAME_BITS;
        end
        // transmitter
        tx_div = tx_div - 8'd1;
        if (tx_div == 8'd0) begin
          tx_div = TX_DIV_RELOAD;
          case (tx_phase)
            PH_START: begin
              tx_line = 1'b0;
              tx_shift = tx_fifo[rd_ptr];
              fifo_not_full = 1'b1;
              rd_ptr = step_ptr(rd_ptr);
              if (rd_ptr == wr_ptr) tx_pending = 1'b0;
              tx_bits = TX_FRAME_BITS;
              tx_phase = PH_SEND;
            end
            PH_SEND: begin
              tx_line = tx_shift[0];
              tx_shift = tx_shift >> 1;
              tx_bits = tx_bits - 4'd1;
              if (tx_bits == 4'd0) tx_phase = PH_STOP;
            end
            PH_STOP: begin
              tx_line = 1'b1;
              tx_phase = PH_IDLE;
            end
            default: ;
          endcase
        end
        if (tx_div == TX_DIV_ARM && tx_phase == PH_IDLE && tx_pending) tx_phase = PH_START;
      end
      r.tx_level = tx_line;
      r.queue_full = !fifo_not_full;
      predicted_results.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned exp_val, int unsigned act_val);
      if (exp_val != act_val) begin
        $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, exp_val, act_val);
        errors++;
      end
    endfunction

    // compare one accepted result with the oldest prediction
    function void check_result(uart_result_t actual);
      uart_result_t exp_r;
      if (predicted_results.size() == 0) begin
        $display("%0t ns: result with no request waiting, expected none actual %0h",
                 $time, actual);
        errors++;
        return;
      end
      exp_r = predicted_results.pop_front();
      compare_field("tx_level", exp_r.tx_level, actual.tx_level);
      compare_field("put_status", exp_r.put_status, actual.put_status);
      compare_field("rx_valid", exp_r.rx_valid, actual.rx_valid);
      compare_field("rx_byte", exp_r.rx_byte, actual.rx_byte);
      compare_field("queue_full", exp_r.queue_full, actual.queue_full);
    endfunction

    function int outstanding();
      return predicted_results.size();
    endfunction
  endclass

endpackage

@@ tb/testbench.sv @@
// testbench: drives ticks, uart frames and puts into uart_transceiver_oversampled
// depends on uto_pkg, uart_line_predictor_pkg and the rtl of the transceiver
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import uto_pkg::*;
  import uart_line_predictor_pkg::*;

  // clock, reset and block inputs start at known values
  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_op = 1'b0;
  logic       in_rx_level = 1'b1;
  logic [7:0] in_wr_byte = 8'h00;
  logic       out_stall = 1'b0;

  logic       in_stall;
  logic       out_valid;
  logic       out_tx_level;
  logic       out_put_status;
  logic       out_rx_valid;
  logic [7:0] out_rx_byte;
  logic       out_queue_full;

  uart_result_t       observed_result;
  uart_line_predictor line_model = new();
  uto_item_t          pending_requests[$];

  uart_transceiver_oversampled #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_rx_level   (in_rx_level),
    .in_wr_byte    (in_wr_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_tx_level  (out_tx_level),
    .out_put_status(out_put_status),
    .out_rx_valid  (out_rx_valid),
    .out_rx_byte   (out_rx_byte),
    .out_queue_full(out_queue_full)
  );

  // 2 ns period
  always #1 clk = ~clk;

  assign observed_result = {out_tx_level, out_put_status, out_rx_valid, out_rx_byte,
                            out_queue_full};

  // monitor: values sampled at the edge are the ones the handshake saw
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) line_model.check_result(observed_result);
      if (in_valid && !in_stall) line_model.note_request(op_t'(in_op), in_rx_level, in_wr_byte);
    end
  end

  // queue one put request; rx_level rides along with random content
  task automatic add_put(logic [7:0] data);
    uto_item_t item;
    item.op = OP_PUT;
    item.rx_level = 1'($urandom);
    item.wr_byte = data;
    pending_requests.push_back(item);
  endtask

  // queue count ticks at one line level, each preceded by a put with put_pct chance
  task automatic add_ticks(logic level, int count, int put_pct);
    uto_item_t item;
    repeat (count) begin
      if ($urandom_range(1, 100) <= put_pct) add_put(8'($urandom));
      item.op = OP_TICK;
      item.rx_level = level;
      item.wr_byte = 8'($urandom);
      pending_requests.push_back(item);
    end
  endtask

  // sender: bursts of random length, random idle gaps between bursts
  task automatic send_requests();
    uto_item_t item;
    int burst;
    int gap;
    while (pending_requests.size() != 0) begin
      // now and then a long burst with no idling at all
      burst = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 12);
      while (burst > 0 && pending_requests.size() != 0) begin
        item = pending_requests.pop_front();
        in_valid <= 1'b1;
        in_op <= item.op;
        in_rx_level <= item.rx_level;
        in_wr_byte <= item.wr_byte;
        // hold the request until it is taken
        do @(posedge clk); while (in_stall);
        burst--;
      end
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  // receiver stall pattern: segments of free flow, light, heavy and periodic stall
  initial begin : result_stall
    int mode;
    int period;
    int seg_left;
    int cycle;
    bit held_off;
    mode = 0;
    period = 2;
    seg_left = 0;
    cycle = 0;
    held_off = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (seg_left == 0) begin
        mode = $urandom_range(0, 3);
        period = $urandom_range(2, 5);
        seg_left = $urandom_range(20, 60);
      end
      seg_left--;
      cycle++;
      if (!held_off && cycle >= 300) begin
        // long hold-off while the sender keeps offering, fills the block up
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (80) @(posedge clk);
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 30);
          2: out_stall <= ($urandom_range(0, 99) < 75);
          default: out_stall <= (cycle % period == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // main flow: reset, directed requests, random frames, drain, verdict
  initial begin : main_flow
    int choice;
    int put_rate;
    logic [7:0] data;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: fill the queue with extreme bytes, then a rejected put
    add_put(8'h00);
    add_put(8'hFF);
    add_put(8'hA5);
    add_put(8'h5A);
    add_put(8'h3C);
    // ticks at both levels: start detect, then line activity
    add_ticks(1'b0, 1, 0);
    add_ticks(1'b1, 4, 0);
    add_ticks(1'b0, 4, 0);
    add_ticks(1'b1, 4, 0);
    // still full, rejected again
    add_put(8'hC3);

    // random: mostly well-formed 8n1 frames at 3 ticks per bit, puts mixed in
    while (pending_requests.size() < 430) begin
      choice = $urandom_range(0, 9);
      // put density per stretch, from draining to filling the queue
      put_rate = $urandom_range(0, 3) * 8;
      if (choice < 7) begin
        data = 8'($urandom);
        add_ticks(1'b1, $urandom_range(0, 4), put_rate);
        add_ticks(1'b0, 3, put_rate);
        for (int b = 0; b < 8; b++) add_ticks(data[b], 3, put_rate);
        // stop bit of random length, sometimes low; short ones hit the restart tick
        add_ticks($urandom_range(0, 7) != 0, $urandom_range(1, 4), put_rate);
      end else if (choice < 9) begin
        // line noise
        repeat ($urandom_range(1, 12)) add_ticks(1'($urandom), $urandom_range(1, 3), put_rate);
      end else begin
        // frame cut short
        add_ticks(1'b0, 3, put_rate);
        repeat ($urandom_range(1, 5)) add_ticks(1'($urandom), 3, put_rate);
      end
    end

    send_requests();

    // drain, then keep running to catch stray results
    while (line_model.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (line_model.errors == 0 && line_model.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #400000;
    $display("tb: failure");
    $finish;
  end

endmodule
